// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; defining ASSERT_OFF removes them all.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// The property must hold at every rising clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

// ===== rtl/core/hb64_pkg.sv =====
// ---------------------------------------------------------------------------
// Hex or base64 decoder package
// Types and codes shared by the decoder core and its character classifier.
// ---------------------------------------------------------------------------
package hb64_pkg;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_CHAR = 2'd1,
      STATUS_ODD_HEX  = 2'd2
   } status_type;

   localparam logic [7:0] CHAR_PAD   = 8'h3d;  // '='
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;  // '+'
   localparam logic [7:0] CHAR_SLASH = 8'h2f;  // '/'
   localparam logic [5:0] B64_LOWER_BASE = 6'd26;
   localparam logic [5:0] B64_DIGIT_BASE = 6'd52;
   localparam logic [5:0] B64_PLUS_VAL   = 6'd62;
   localparam logic [5:0] B64_SLASH_VAL  = 6'd63;

   // Classification of one character for both alphabets.
   typedef struct packed {
      logic       hex_ok;
      logic [3:0] hex_val;
      logic       b64_ok;
      logic [5:0] b64_val;
      logic       is_pad;
   } char_class_type;

   // Per-blob decoding state.
   typedef struct packed {
      logic [3:0]  high_nibble;
      logic        hex_phase;
      logic [11:0] bit_acc;
      logic [2:0]  bit_count;
      logic        padding_seen;
      logic        error_latched;
   } blob_state_type;

   localparam blob_state_type BLOB_CLEAR = '0;

endpackage

// ===== rtl/core/hb64_char_class.sv =====
// ---------------------------------------------------------------------------
// Character classifier
// Maps one character code to its hex digit value and base64 sextet value.
// ---------------------------------------------------------------------------
module hb64_char_class
   import hb64_pkg::*;
(
   input  logic [7:0]     char_code,
   output char_class_type char_class
);

   logic [7:0] off_digit;
   logic [7:0] off_lower;
   logic [7:0] off_upper;
   logic       is_digit;
   logic       is_lower;
   logic       is_upper;

   always_comb begin
      off_digit = char_code - 8'h30;
      off_lower = char_code - 8'h61;
      off_upper = char_code - 8'h41;
      is_digit  = (char_code >= 8'h30) && (char_code <= 8'h39);
      is_lower  = (char_code >= 8'h61) && (char_code <= 8'h7a);
      is_upper  = (char_code >= 8'h41) && (char_code <= 8'h5a);

      char_class = '0;
      char_class.is_pad = (char_code == CHAR_PAD);

      // Hex digits in either case.
      if (is_digit) begin
         char_class.hex_ok  = 1'b1;
         char_class.hex_val = off_digit[3:0];
      end else if (is_lower && (off_lower < 8'd6)) begin
         char_class.hex_ok  = 1'b1;
         char_class.hex_val = 4'(off_lower[3:0] + 4'd10);
      end else if (is_upper && (off_upper < 8'd6)) begin
         char_class.hex_ok  = 1'b1;
         char_class.hex_val = 4'(off_upper[3:0] + 4'd10);
      end

      // Standard base64 alphabet.
      if (is_upper) begin
         char_class.b64_ok  = 1'b1;
         char_class.b64_val = off_upper[5:0];
      end else if (is_lower) begin
         char_class.b64_ok  = 1'b1;
         char_class.b64_val = 6'(off_lower[5:0] + B64_LOWER_BASE);
      end else if (is_digit) begin
         char_class.b64_ok  = 1'b1;
         char_class.b64_val = 6'(off_digit[5:0] + B64_DIGIT_BASE);
      end else if (char_code == CHAR_PLUS) begin
         char_class.b64_ok  = 1'b1;
         char_class.b64_val = B64_PLUS_VAL;
      end else if (char_code == CHAR_SLASH) begin
         char_class.b64_ok  = 1'b1;
         char_class.b64_val = B64_SLASH_VAL;
      end
   end

endmodule

// ===== rtl/core/hex_or_base64_blob_decoder_core.sv =====
// ---------------------------------------------------------------------------
// Hex or base64 blob decoder core
// Streams text characters in and decoded bytes out, one character a clock while the result side keeps up.
// ---------------------------------------------------------------------------
// The core accepts one text character per clock and sustains that rate
// indefinitely while the result side keeps up; a character travels through
// an input register and then a result register, from which the result is
// presented to the result side. The rate is set by the update of the
// per-blob state (hex nibble, base64 bit accumulator and
// error flag) between the two registers. A non-final character yields a
// result transaction only when it completes a byte; the final character of
// a blob always yields exactly one result with end_of_blob set, unless an
// error has already been reported for that blob. The first error in a blob
// gives one result with its status and end_of_blob set, after which the
// remaining characters up to and including the final one are swallowed.
// The mode register may only be written while the core is empty and no
// character is being offered, which is what csr_ready reports.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hex_or_base64_blob_decoder_core
   import hb64_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // Character input channel.
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_final_char,
   // Decoded result channel.
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_end_of_blob,
   output logic [1:0] rsp_status,
   // Mode register write channel.
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_base64_mode
);

   // Mode register.
   logic mode_ff;
   logic mode_in;

   // Input register.
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_final_ff;

   // Blob state.
   blob_state_type blob_ff;
   blob_state_type blob_in;

   // Result register.
   logic       out_valid_ff;
   logic       out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_bvalid_ff;
   logic       out_end_ff;
   status_type out_status_ff;

   char_class_type cls;

   logic       out_free;
   logic       fire;
   logic       in_accept;
   logic       has_result;
   status_type status;
   logic       have_byte;
   logic [7:0] byte_val;
   logic [3:0] count_sum;
   logic [2:0] count_new;
   logic [11:0] acc_new;

   hb64_char_class u_char_class (
      .char_code  (in_char_ff),
      .char_class (cls)
   );

   // Decode step for the character held in the input register.
   always_comb begin
      blob_in   = blob_ff;
      status    = STATUS_OK;
      have_byte = 1'b0;
      byte_val  = 8'h00;
      acc_new   = {blob_ff.bit_acc[5:0], cls.b64_val};
      count_sum = {1'b0, blob_ff.bit_count} + 4'd6;
      count_new = count_sum[2:0];

      if (!blob_ff.error_latched) begin
         if (!mode_ff) begin
            if (!blob_ff.hex_phase) begin
               // A final character where a high digit is due means odd length.
               if (in_final_ff) begin
                  status = STATUS_ODD_HEX;
               end else if (!cls.hex_ok) begin
                  status = STATUS_BAD_CHAR;
               end else begin
                  blob_in.high_nibble = cls.hex_val;
                  blob_in.hex_phase   = 1'b1;
               end
            end else begin
               if (!cls.hex_ok) begin
                  status = STATUS_BAD_CHAR;
               end else begin
                  byte_val          = {blob_ff.high_nibble, cls.hex_val};
                  have_byte         = 1'b1;
                  blob_in.hex_phase = 1'b0;
               end
            end
         end else begin
            if (cls.is_pad) begin
               blob_in.padding_seen = 1'b1;
            end else if (blob_ff.padding_seen || !cls.b64_ok) begin
               status = STATUS_BAD_CHAR;
            end else begin
               blob_in.bit_acc = acc_new;
               if (count_sum >= 4'd8) begin
                  count_new = 3'(count_sum - 4'd8);
                  byte_val  = 8'(acc_new >> count_new);
                  have_byte = 1'b1;
               end
               blob_in.bit_count = count_new;
            end
         end

         if (status != STATUS_OK) begin
            blob_in = blob_ff;
            blob_in.error_latched = 1'b1;
         end
      end

      if (in_final_ff) begin
         blob_in = BLOB_CLEAR;
      end
   end

   // Handshake control.
   always_comb begin
      has_result   = !blob_ff.error_latched
                     && ((status != STATUS_OK) || in_final_ff || have_byte);
      out_free     = !out_valid_ff || !rsp_stall;
      fire         = in_valid_ff && (!has_result || out_free);
      req_stall    = in_valid_ff && !fire;
      in_accept    = req_valid && !req_stall;
      in_valid_in  = in_accept || (in_valid_ff && !fire);
      out_valid_in = (fire && has_result) || (out_valid_ff && rsp_stall);
      csr_ready    = !in_valid_ff && !out_valid_ff && !req_valid;
      mode_in      = (csr_valid && csr_ready) ? csr_base64_mode : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         blob_ff      <= BLOB_CLEAR;
      end else begin
         mode_ff      <= mode_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            blob_ff <= blob_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         in_char_ff  <= req_char_code;
         in_final_ff <= req_final_char;
      end
      if (fire && has_result) begin
         out_byte_ff   <= (status == STATUS_OK) ? byte_val : 8'h00;
         out_bvalid_ff <= (status == STATUS_OK) && have_byte;
         out_end_ff    <= (status != STATUS_OK) || in_final_ff;
         out_status_ff <= status;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_data_byte   = out_byte_ff;
   assign rsp_byte_valid  = out_bvalid_ff;
   assign rsp_end_of_blob = out_end_ff;
   assign rsp_status      = out_status_ff;

   // The base64 bit count only ever steps through even values.
   `ASSERT_NEVER(a_count_even, clock, reset, blob_ff.bit_count[0],
      "base64 bit count became odd")
   // An error result never carries a byte, and always ends the blob.
   `ASSERT_NEVER(a_err_no_byte, clock, reset,
      rsp_valid && (rsp_status != STATUS_OK) && (rsp_byte_valid || !rsp_end_of_blob),
      "error result carries a byte or does not end the blob")
   // A final character leaves the blob state cleared.
   `ASSERT_HOLDS(a_final_clears, clock, reset,
      (fire && in_final_ff) |=> (blob_ff == BLOB_CLEAR),
      "blob state not cleared after final character")
   // Latching an error coincides with its error result being loaded.
   `ASSERT_HOLDS(a_err_reported, clock, reset,
      $rose(blob_ff.error_latched) |-> (rsp_valid && (rsp_status != STATUS_OK)),
      "error latched without an error result")

endmodule

// ===== verif/hex_or_base64_blob_decoder_core_tb.sv =====
// ---------------------------------------------------------------------------
// Hex or base64 blob decoder core testbench
// Streams hex and base64 blobs, both clean and damaged, through the core
// under several idling patterns, and checks every result in order against
// a scoreboard that decodes the same characters.
// ---------------------------------------------------------------------------

typedef struct {
   logic [7:0]           data;
   logic                 byte_ok;
   logic                 last;
   hb64_pkg::status_type status;
} decoded_item_type;

// Keeps its own copy of the mode and the per-blob decoding state, and
// queues the result that each accepted character should produce.
class blob_decode_scoreboard;
   logic             base64 = 1'b0;
   logic [3:0]       nibble;
   logic             low_digit_due;
   logic [11:0]      acc;
   int               acc_bits;
   logic             pad_seen;
   logic             err_latched;
   decoded_item_type decoded_q[$];
   int               errors = 0;
   int               chars_seen = 0;
   int               results_checked = 0;
   int               error_results = 0;

   function new();
      clear_blob();
   endfunction

   function void clear_blob();
      nibble        = '0;
      low_digit_due = 1'b0;
      acc           = '0;
      acc_bits      = 0;
      pad_seen      = 1'b0;
      err_latched   = 1'b0;
   endfunction

   function int pending();
      return decoded_q.size();
   endfunction

   function int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function int b64_value(logic [7:0] c);
      if (c >= "A" && c <= "Z") return int'(c) - int'("A");
      if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
      if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
      if (c == hb64_pkg::CHAR_PLUS) return 62;
      if (c == hb64_pkg::CHAR_SLASH) return 63;
      return -1;
   endfunction

   // Decodes one accepted character and queues the result it causes, if any.
   function void note_char(logic [7:0] c, logic fin);
      hb64_pkg::status_type st;
      logic [7:0]           value;
      logic                 have;
      int                   v;
      st    = hb64_pkg::STATUS_OK;
      value = '0;
      have  = 1'b0;
      chars_seen++;
      // Once an error has been reported the rest of the blob is swallowed.
      if (err_latched) begin
         if (fin) clear_blob();
         return;
      end
      if (!base64) begin
         v = hex_value(c);
         if (!low_digit_due) begin
            if (fin) st = hb64_pkg::STATUS_ODD_HEX;
            else if (v < 0) st = hb64_pkg::STATUS_BAD_CHAR;
            else begin
               nibble        = v[3:0];
               low_digit_due = 1'b1;
            end
         end else if (v < 0) begin
            st = hb64_pkg::STATUS_BAD_CHAR;
         end else begin
            value         = {nibble, v[3:0]};
            have          = 1'b1;
            low_digit_due = 1'b0;
         end
      end else begin
         if (c == hb64_pkg::CHAR_PAD) begin
            pad_seen = 1'b1;
         end else if (pad_seen) begin
            st = hb64_pkg::STATUS_BAD_CHAR;
         end else begin
            v = b64_value(c);
            if (v < 0) st = hb64_pkg::STATUS_BAD_CHAR;
            else begin
               acc      = {acc[5:0], v[5:0]};
               acc_bits = acc_bits + 6;
               if (acc_bits >= 8) begin
                  acc_bits = acc_bits - 8;
                  value    = 8'(acc >> acc_bits);
                  have     = 1'b1;
               end
            end
         end
      end
      if (st != hb64_pkg::STATUS_OK) begin
         decoded_q.push_back('{8'h00, 1'b0, 1'b1, st});
         error_results++;
         if (fin) clear_blob();
         else err_latched = 1'b1;
      end else if (fin) begin
         decoded_q.push_back('{have ? value : 8'h00, have, 1'b1, hb64_pkg::STATUS_OK});
         clear_blob();
      end else if (have) begin
         decoded_q.push_back('{value, 1'b1, 1'b0, hb64_pkg::STATUS_OK});
      end
   endfunction

   task report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   task check_result(logic [7:0] data, logic byte_ok, logic last, logic [1:0] status);
      decoded_item_type want;
      if (decoded_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result %02h valid %b end %b status %0d",
                                   data, byte_ok, last, status));
         return;
      end
      want = decoded_q.pop_front();
      results_checked++;
      if (data !== want.data)
         report_mismatch($sformatf("data_byte %02h, expected %02h", data, want.data));
      if (byte_ok !== want.byte_ok)
         report_mismatch($sformatf("byte_valid %b, expected %b", byte_ok, want.byte_ok));
      if (last !== want.last)
         report_mismatch($sformatf("end_of_blob %b, expected %b", last, want.last));
      if (status !== want.status)
         report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
   endtask
endclass

module hex_or_base64_blob_decoder_core_tb;
   import hb64_pkg::*;

   localparam int LIMIT_CYCLES    = 400000;
   localparam int SETTLE_CYCLES   = 6;
   localparam int ITEMS_PER_PHASE = 130;
   localparam int SEND_IDLE[4]    = '{0, 64, 0, 31};
   localparam int RSP_STALL[4]    = '{0, 0, 64, 31};

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_code   = 8'h00;
   logic       req_final_char  = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [7:0] rsp_data_byte;
   logic       rsp_byte_valid;
   logic       rsp_end_of_blob;
   logic [1:0] rsp_status;
   logic       csr_valid       = 1'b0;
   logic       csr_ready;
   logic       csr_base64_mode = 1'b0;

   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          phase_items   = 0;
   int unsigned cycles        = 0;
   blob_decode_scoreboard sb;

   hex_or_base64_blob_decoder_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .req_final_char  (req_final_char),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_end_of_blob (rsp_end_of_blob),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_base64_mode (csr_base64_mode)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("Run timed out with %0d results outstanding.", sb.pending());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // The receiver stalls at random with the chance that the current phase sets.
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // Every result transaction is checked against the oldest queued prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_data_byte, rsp_byte_valid, rsp_end_of_blob, rsp_status);
   end

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'("0") + 8'(v);
      if ($urandom_range(1) == 0) return 8'("a") + 8'(v - 4'd10);
      return 8'("A") + 8'(v - 4'd10);
   endfunction

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      if (v < B64_LOWER_BASE) return 8'("A") + 8'(v);
      if (v < B64_DIGIT_BASE) return 8'("a") + 8'(v - B64_LOWER_BASE);
      if (v < B64_PLUS_VAL) return 8'("0") + 8'(v - B64_DIGIT_BASE);
      if (v == B64_PLUS_VAL) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   // Offers one character and returns once its transaction has been accepted.
   task automatic send_char(input logic [7:0] c, input logic fin);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_char_code  <= c;
      req_final_char <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_char(c, fin);
      phase_items++;
   endtask

   task automatic send_text(input string s, input logic closes);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], closes && (i == s.len() - 1));
   endtask

   // Mostly well-formed blobs with random content; the rest carry stray
   // bytes, misplaced padding or an odd digit count.
   task automatic send_blob(input logic b64);
      int         len;
      int         pads;
      int         roll;
      logic [7:0] c;
      logic       broken;
      broken = ($urandom_range(99) < 20);
      if (!b64) len = broken ? $urandom_range(1, 9) : 2 * $urandom_range(1, 6);
      else len = $urandom_range(1, 12);
      pads = (b64 && !broken) ? $urandom_range(0, 2) : 0;
      for (int i = 0; i < len + pads; i++) begin
         roll = $urandom_range(99);
         if (i >= len) c = CHAR_PAD;
         else if (broken && roll < 20) c = 8'($urandom_range(255));
         else if (broken && b64 && roll < 35) c = CHAR_PAD;
         else if (b64) c = b64_char(6'($urandom_range(63)));
         else c = hex_char(4'($urandom_range(15)));
         send_char(c, i == len + pads - 1);
      end
   endtask

   // The mode is only written once every expected result has arrived and
   // any character that gives no result has had time to leave the core.
   task automatic write_mode(input logic m);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_base64_mode <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.base64 = m;
   endtask

   initial begin
      logic mode;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Hex: both letter cases, a byte mid-blob and one on the final
      // character, the byte value ff as a bad digit whose blob swallows the final
      // 00, an odd length and a bad low digit on the final character.
      write_mode(1'b0);
      send_text("0aF9", 1'b1);
      send_char(8'hff, 1'b0);
      send_char(8'h00, 1'b1);
      send_text("A", 1'b1);
      send_text("5z", 1'b1);
      // A high digit left pending across a change to base64.
      send_text("7", 1'b0);
      write_mode(1'b1);
      // Base64: a whole group, plus, slash and padding, a character after
      // padding, and a character outside the alphabet.
      send_text("TWFu", 1'b1);
      send_text("+/9=", 1'b1);
      send_text("Z=xA", 1'b1);
      send_text("*", 1'b1);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = SEND_IDLE[p];
         stall_pct     = RSP_STALL[p];
         for (int k = 0; k < 2; k++) begin
            mode = ((p + k) % 2) == 1;
            write_mode(mode);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) send_blob(mode);
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Decoded %0d characters in hex and base64 under four idling patterns,",
               sb.chars_seen);
      $display("checking %0d results, %0d of them error reports.",
               sb.results_checked, sb.error_results);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/hb64_pkg.sv
rtl/core/hb64_char_class.sv
rtl/core/hex_or_base64_blob_decoder_core.sv
verif/hex_or_base64_blob_decoder_core_tb.sv
